// ===== rtl/core/mgvf_pkg.sv =====
// Shared types, register codes and defaults for the MGVF stencil line buffer.
package mgvf_pkg;

  localparam int LINE_WIDTH_DEF    = 512;
  localparam int MAX_ROWS_DEF      = 1024;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IS_EDGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_IS_EDGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BAND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MU_OVER_LAMBDA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LAMBDA     = 3'd5;

  localparam logic [10:0] ROWS_RST = 11'd1024;
  localparam logic [15:0] BAND_RST = 16'd1678;
  localparam logic [30:0] MU_RST   = 31'd8388608;
  localparam logic [30:0] INV_RST  = 31'd16777216;

  // Product magnitudes are capped at 2^48.
  localparam int CAP_BITS = 48;

  typedef struct packed {
    logic [10:0] rows_in_use;
    logic        top_is_edge;
    logic        bottom_is_edge;
    logic [15:0] step_band;
    logic [30:0] mu_over_lambda;
    logic [30:0] inv_lambda;
  } mgvf_cfg_t;

  // One centre pixel ready for arithmetic: neighbours already edge-replaced.
  typedef struct packed {
    logic [7:0][SAMPLE_W-1:0] nb;
    logic [SAMPLE_W-1:0]      c;
    logic [SAMPLE_W-1:0]      g;
    logic                     last;
  } mgvf_job_t;

endpackage

// ===== rtl/core/mgvf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mgvf_ram
  import mgvf_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mgvf_fifo.sv =====
// Small register FIFO with count-based full and empty flags.
module mgvf_fifo
  import mgvf_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNW'(1);
      end
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign full  = (cnt_r == CNW'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

// ===== rtl/core/mgvf_front.sv =====
// Front end: line buffer, 3x3 window, frame position and edge classification.
module mgvf_front
  import mgvf_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [SAMPLE_W-1:0] field_sample,
  input  logic [SAMPLE_W-1:0] guide_sample,
  input  logic                drain,
  input  mgvf_cfg_t           cfg,
  output logic                produce,
  output mgvf_job_t           job
);

  localparam int CLW = $clog2(LINE_WIDTH);
  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int QW  = RW + 1;
  localparam int CW  = (RW > 11) ? RW : 11;

  logic [CLW-1:0] ptr_r, ptr_nxt, raddr;
  logic [RW-1:0]  row_r;
  logic [CLW-1:0] col_r;
  logic [SAMPLE_W-1:0] b1_r, b2_r, m1_r, m2_r, t1_r, t2_r, gd_r;
  logic [SAMPLE_W-1:0] fnew, gnew, mid_f, mid_g, top_f;
  logic [2*SAMPLE_W-1:0] ram_a_q;

  logic [CW-1:0]          rin;
  logic [RW-1:0]          rows_c;
  logic signed [QW-1:0]   row_s, rows_s, qr, first_s, last_s;
  logic [CLW-1:0]         qc;
  logic                   e_top, e_bot, e_left, e_right;
  logic [SAMPLE_W-1:0]    c;

  assign fnew = drain ? '0 : field_sample;
  assign gnew = drain ? '0 : guide_sample;

  assign ptr_nxt = (ptr_r == CLW'(LINE_WIDTH - 1)) ? '0 : ptr_r + CLW'(1);
  // Prefetch the next slot on a transfer so read data always mirrors ptr_r.
  assign raddr = acc ? ptr_nxt : ptr_r;

  mgvf_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(LINE_WIDTH)) u_ram_mid (
    .clk(clk), .we(acc), .waddr(ptr_r), .wdata({gnew, fnew}),
    .raddr(raddr), .rdata(ram_a_q)
  );

  assign mid_f = ram_a_q[SAMPLE_W-1:0];
  assign mid_g = ram_a_q[2*SAMPLE_W-1:SAMPLE_W];

  mgvf_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_WIDTH)) u_ram_top (
    .clk(clk), .we(acc), .waddr(ptr_r), .wdata(mid_f),
    .raddr(raddr), .rdata(top_f)
  );

  // Clamp the row count to the supported range.
  assign rin = CW'(cfg.rows_in_use);
  always_comb begin
    if (rin < CW'(3)) begin
      rows_c = RW'(3);
    end else if (rin > CW'(MAX_ROWS)) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(rin);
    end
  end

  assign row_s   = $signed({1'b0, row_r});
  assign rows_s  = $signed({1'b0, rows_c});
  assign qr      = (col_r != '0) ? row_s - QW'(1) : row_s - QW'(2);
  assign qc      = (col_r != '0) ? col_r - CLW'(1) : CLW'(LINE_WIDTH - 1);
  assign first_s = cfg.top_is_edge ? '0 : QW'(1);
  assign last_s  = rows_s - QW'(1) - (cfg.bottom_is_edge ? '0 : QW'(1));

  assign produce = (qr >= first_s) && (qr <= last_s);
  assign e_top   = cfg.top_is_edge && (qr == '0);
  assign e_bot   = cfg.bottom_is_edge && (qr == rows_s - QW'(1));
  assign e_left  = (qc == '0);
  assign e_right = (qc == CLW'(LINE_WIDTH - 1));

  assign c = m1_r;

  always_comb begin
    job.c     = c;
    job.g     = gd_r;
    job.last  = (qr == last_s) && e_right;
    job.nb[0] = (e_top || e_left)  ? c : t2_r;
    job.nb[1] = e_top              ? c : t1_r;
    job.nb[2] = (e_top || e_right) ? c : top_f;
    job.nb[3] = e_left             ? c : m2_r;
    job.nb[4] = e_right            ? c : mid_f;
    job.nb[5] = (e_bot || e_left)  ? c : b2_r;
    job.nb[6] = e_bot              ? c : b1_r;
    job.nb[7] = (e_bot || e_right) ? c : fnew;
  end

  // Window taps shift on every transfer.
  always_ff @(posedge clk) begin
    if (acc) begin
      b1_r <= fnew;
      b2_r <= b1_r;
      m1_r <= mid_f;
      m2_r <= m1_r;
      t1_r <= top_f;
      t2_r <= t1_r;
      gd_r <= mid_g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      ptr_r <= ptr_nxt;
      if (row_r >= rows_c + RW'(1)) begin
        row_r <= '0;
        col_r <= '0;
      end else if (col_r == CLW'(LINE_WIDTH - 1)) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CLW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mgvf_back.sv =====
// Back end: step weighting, two scaled products with rounding, saturation.
module mgvf_back
  import mgvf_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mgvf_job_t           job,
  input  logic                job_valid,
  output logic                job_pop,
  input  mgvf_cfg_t           cfg,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,
  output logic                out_tlast
);

  localparam int NST = 11;
  localparam int OUT_DEPTH = NST + 2;
  localparam int IFW = $clog2(OUT_DEPTH + 1);
  localparam int VS5 = 49;
  localparam logic [VS5-1:0] CAP = VS5'(1) << CAP_BITS;

  typedef struct packed {
    logic [SAMPLE_W-1:0] c;
    logic [SAMPLE_W-1:0] g;
    logic [SAMPLE_W-1:0] vhe;
    logic                last;
  } side_t;

  function automatic logic [SAMPLE_W-1:0] sat32(input logic [50:0] v);
    logic [SAMPLE_W-1:0] r;
    if ((v[50:31] == '0) || (v[50:31] == '1)) begin
      r = v[31:0];
    end else if (v[50]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic [NST-1:0] vld_r;
  side_t          side_r [NST];
  logic [IFW-1:0] infl_r;
  logic           of_pop, of_full, of_empty;

  logic signed [33:0] w_r [8];
  logic signed [37:0] sum_r;
  logic [36:0]        smag_r;
  logic               sneg3_r, sneg4_r, sneg5_r;
  logic [62:0]        plo_r;
  logic [35:0]        phi_r;
  logic [VS5-1:0]     mag1_r, mag2_r;
  logic [31:0]        ag_r;
  logic [32:0]        ae_r;
  logic               pn7_r, pn8_r, pn9_r, pn10_r;
  logic [63:0]        pp_r;
  logic [62:0]        qlo_r, qhi_r;
  logic [SAMPLE_W-1:0] res_r;

  logic signed [33:0] w_nxt [8];
  logic signed [37:0] sum_nxt;
  logic [37:0]        abs_nxt;
  logic [68:0]        p1_full, p1_rnd, p1_q;
  logic [VS5-1:0]     mag1_nxt, mag2_nxt;
  logic signed [50:0] v6, sum6;
  logic signed [32:0] g7, e7;
  logic [32:0]        ag7, ae7;
  logic [64:0]        pp_nxt;
  logic [95:0]        p2_full, p2_q;
  logic signed [50:0] v11, sum11;

  // Take a job only while the output queue has room for everything in flight.
  assign job_pop = job_valid && (infl_r < IFW'(OUT_DEPTH));
  assign of_pop  = out_tvalid && out_tready;
  assign out_tvalid = !of_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      infl_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], job_pop};
      if (job_pop && !of_pop) begin
        infl_r <= infl_r + IFW'(1);
      end else if (of_pop && !job_pop) begin
        infl_r <= infl_r - IFW'(1);
      end
    end
  end

  // Step weights: 0, 1/2 or 1 of the difference (kept as 0, d or 2d).
  always_comb begin
    logic signed [32:0] cs, band, d;
    cs   = $signed({job.c[31], job.c});
    band = $signed({17'b0, cfg.step_band});
    for (int k = 0; k < 8; k++) begin
      d = $signed({job.nb[k][31], job.nb[k]}) - cs;
      if (d > band) begin
        w_nxt[k] = $signed({d, 1'b0});
      end else if (d > -band) begin
        w_nxt[k] = $signed({d[32], d});
      end else begin
        w_nxt[k] = '0;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      sum_nxt = sum_nxt + 38'(w_r[k]);
    end
  end

  assign abs_nxt = sum_r[37] ? 38'(-sum_r) : 38'(sum_r);

  assign p1_full = 69'(plo_r) + (69'(phi_r) << 32);
  assign p1_rnd  = p1_full + (69'(1) << FRACTION_BITS);
  assign p1_q    = p1_rnd >> (FRACTION_BITS + 1);
  assign mag1_nxt = (p1_q > 69'(CAP)) ? CAP : p1_q[VS5-1:0];

  assign v6   = sneg5_r ? -$signed({2'b0, mag1_r}) : $signed({2'b0, mag1_r});
  assign sum6 = $signed({{19{side_r[4].c[31]}}, side_r[4].c}) + v6;

  assign g7  = $signed({side_r[5].g[31], side_r[5].g});
  assign e7  = $signed({side_r[5].vhe[31], side_r[5].vhe}) - g7;
  assign ag7 = g7[32] ? 33'(-g7) : 33'(g7);
  assign ae7 = e7[32] ? 33'(-e7) : 33'(e7);

  assign pp_nxt = 65'(ag_r) * 65'(ae_r);

  assign p2_full  = 96'(qlo_r) + (96'(qhi_r) << 32)
                  + (96'(1) << (2 * FRACTION_BITS - 1));
  assign p2_q     = p2_full >> (2 * FRACTION_BITS);
  assign mag2_nxt = (p2_q > 96'(CAP)) ? CAP : p2_q[VS5-1:0];

  assign v11   = pn10_r ? -$signed({2'b0, mag2_r}) : $signed({2'b0, mag2_r});
  assign sum11 = $signed({{19{side_r[9].vhe[31]}}, side_r[9].vhe}) - v11;

  // Payload pipeline; stages advance every cycle, vld_r tracks occupancy.
  always_ff @(posedge clk) begin
    side_r[0] <= '{c: job.c, g: job.g, vhe: '0, last: job.last};
    for (int i = 1; i < NST; i++) begin
      if (i != 5) begin
        side_r[i] <= side_r[i-1];
      end
    end
    // Stage five picks up the saturated centre update.
    side_r[5] <= '{c: side_r[4].c, g: side_r[4].g, vhe: sat32(51'(sum6)),
                   last: side_r[4].last};

    for (int k = 0; k < 8; k++) begin
      w_r[k] <= w_nxt[k];
    end
    sum_r   <= sum_nxt;
    smag_r  <= abs_nxt[36:0];
    sneg3_r <= sum_r[37];
    plo_r   <= 63'(smag_r[31:0]) * 63'(cfg.mu_over_lambda);
    phi_r   <= 36'(smag_r[36:32]) * 36'(cfg.mu_over_lambda);
    sneg4_r <= sneg3_r;
    mag1_r  <= mag1_nxt;
    sneg5_r <= sneg4_r;
    ag_r    <= ag7[31:0];
    ae_r    <= ae7;
    pn7_r   <= g7[32] ^ e7[32];
    pp_r    <= pp_nxt[63:0];
    pn8_r   <= pn7_r;
    qlo_r   <= 63'(pp_r[31:0]) * 63'(cfg.inv_lambda);
    qhi_r   <= 63'(pp_r[63:32]) * 63'(cfg.inv_lambda);
    pn9_r   <= pn8_r;
    mag2_r  <= mag2_nxt;
    pn10_r  <= pn9_r;
    res_r   <= sat32(51'(sum11));
  end

  mgvf_fifo #(.WIDTH(SAMPLE_W + 1), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(vld_r[NST-1]), .din({side_r[NST-1].last, res_r}),
    .pop(of_pop), .dout({out_tlast, out_tdata}),
    .full(of_full), .empty(of_empty)
  );

  logic unused_full;
  assign unused_full = of_full;

endmodule

// ===== rtl/core/mgvf_stencil_line_buffer_unit.sv =====
// Top level of the MGVF stencil line buffer: config registers, front, job queue, back.
//
//  channel | ports               | payload (low bits first)
//  --------+---------------------+---------------------------------------------
//  in      | in_tvalid/in_tready | tdata: field_sample, guide_sample; tuser: drain
//  out     | out_tvalid/tready   | tdata: new_value; tlast: last_of_frame
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// One item is taken per cycle while the job queue has room; the line buffer
// RAMs are read and written once per transfer, so the front never waits on
// them. A result leaves after the transfer that completes its 3x3 window,
// through the eleven-stage arithmetic pipeline and two queues. Reset clears
// positions and queues at once; the line RAMs need no clearing pass. The back
// stops pulling jobs when its output queue could overflow, and the front
// stalls only when the four-entry job queue is full.
module mgvf_stencil_line_buffer_unit
  import mgvf_pkg::*;
#(
  parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // field_sample[31:0], guide_sample[63:32]
  input  logic                  in_tuser,   // drain
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // new_value[31:0]
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int JQ_DEPTH = 4;

  mgvf_cfg_t cfg_r;
  logic      acc, produce;
  mgvf_job_t job_in, job_out;
  logic      jq_push, jq_pop, jq_full, jq_empty;

  // Config writes land directly; the user must send them only while the block is idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rows_in_use: ROWS_RST, top_is_edge: 1'b1, bottom_is_edge: 1'b1,
                 step_band: BAND_RST, mu_over_lambda: MU_RST, inv_lambda: INV_RST};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_IN_USE:    cfg_r.rows_in_use    <= cfg_data[10:0];
        REG_TOP_IS_EDGE:    cfg_r.top_is_edge    <= cfg_data[0];
        REG_BOTTOM_IS_EDGE: cfg_r.bottom_is_edge <= cfg_data[0];
        REG_STEP_BAND:      cfg_r.step_band      <= cfg_data[15:0];
        REG_MU_OVER_LAMBDA: cfg_r.mu_over_lambda <= cfg_data;
        REG_INV_LAMBDA:     cfg_r.inv_lambda     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold input whenever the job queue cannot take another centre.
  assign in_tready = !jq_full;
  assign acc       = in_tvalid && in_tready;
  assign jq_push   = acc && produce;

  mgvf_front #(.LINE_WIDTH(LINE_WIDTH), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .field_sample(in_tdata[31:0]), .guide_sample(in_tdata[63:32]),
    .drain(in_tuser), .cfg(cfg_r), .produce(produce), .job(job_in)
  );

  mgvf_fifo #(.WIDTH($bits(mgvf_job_t)), .DEPTH(JQ_DEPTH)) u_job_q (
    .clk(clk), .rst_n(rst_n),
    .push(jq_push), .din(job_in), .pop(jq_pop), .dout(job_out),
    .full(jq_full), .empty(jq_empty)
  );

  mgvf_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job(job_out), .job_valid(!jq_empty), .job_pop(jq_pop), .cfg(cfg_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  a_jq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(jq_push && jq_full && !jq_pop)) else $error("job queue overflow");

  a_jq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(jq_pop && jq_empty)) else $error("job queue underflow");

  a_out_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result presented right after reset");

endmodule

// ===== tb/mgvf_stencil_line_buffer_unit_tb.sv =====
// Testbench for the MGVF stencil line buffer: frames of random samples checked against a predictor.
`timescale 1ns / 1ps

module mgvf_stencil_line_buffer_unit_tb;
  import mgvf_pkg::*;

  localparam int W      = LINE_WIDTH_DEF;
  localparam int WDEPTH = 2 * W + 3;
  localparam int GDEPTH = W + 1;
  localparam int FRAC   = FRACTION_BITS_DEF;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } pixel_t;

  // Pixel predictor plus queue of pixels still to come out of the block.
  class mgvf_scoreboard;
    logic [31:0] field_line [WDEPTH];
    logic [31:0] guide_line [GDEPTH];
    int          field_wp, guide_wp, row_pos, col_pos;
    mgvf_cfg_t   regs;
    pixel_t      pending [$];
    int          errors, checked;

    function new();
      foreach (field_line[i]) field_line[i] = '0;
      foreach (guide_line[i]) guide_line[i] = '0;
      regs = '{ROWS_RST, 1'b1, 1'b1, BAND_RST, MU_RST, INV_RST};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROWS_IN_USE:    regs.rows_in_use    = val[10:0];
        REG_TOP_IS_EDGE:    regs.top_is_edge    = val[0];
        REG_BOTTOM_IS_EDGE: regs.bottom_is_edge = val[0];
        REG_STEP_BAND:      regs.step_band      = val[15:0];
        REG_MU_OVER_LAMBDA: regs.mu_over_lambda = val[30:0];
        REG_INV_LAMBDA:     regs.inv_lambda     = val[30:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // round(a*b / 2^s) away from zero on ties, magnitude capped at 2^CAP_BITS
    function longint scale_round(longint a, logic [30:0] b, int s);
      bit [127:0] mag;
      mag = (a < 0) ? 128'(-a) : 128'(a);
      mag = ((mag * 128'(b)) + (128'd1 << (s - 1))) >> s;
      if (mag > (128'd1 << CAP_BITS)) mag = 128'd1 << CAP_BITS;
      return (a < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function longint field_age(int age);
      return longint'($signed(field_line[(field_wp + WDEPTH - age) % WDEPTH]));
    endfunction

    // Advance the window by one accepted transfer; queue a pixel if one falls out.
    function void note_item(logic [31:0] f, logic [31:0] g, bit drn);
      int     ages [8] = '{2*W+2, 2*W+1, 2*W, W+2, W, 2, 1, 0};
      int     rows, qr, qc, first_row, last_row;
      longint gc, c, d, band, sum2, vhe, pull;
      bit     tp, bt, lf, rt;
      bit     swap [8];
      pixel_t px;
      rows = (regs.rows_in_use < 3) ? 3 : (regs.rows_in_use > MAX_ROWS_DEF) ?
             MAX_ROWS_DEF : int'(regs.rows_in_use);
      gc = longint'($signed(guide_line[guide_wp]));
      guide_line[guide_wp] = drn ? '0 : g;
      guide_wp = (guide_wp + 1) % GDEPTH;
      field_wp = (field_wp + 1) % WDEPTH;
      field_line[field_wp] = drn ? '0 : f;
      if (col_pos >= 1) begin
        qr = row_pos - 1; qc = col_pos - 1;
      end else begin
        qr = row_pos - 2; qc = W - 1;
      end
      first_row = regs.top_is_edge ? 0 : 1;
      last_row  = rows - 1 - (regs.bottom_is_edge ? 0 : 1);
      if (qr >= first_row && qr <= last_row) begin
        tp = regs.top_is_edge && qr == 0;
        bt = regs.bottom_is_edge && qr == rows - 1;
        lf = qc == 0;
        rt = qc == W - 1;
        swap = '{tp || lf, tp, tp || rt, lf, rt, bt || lf, bt, bt || rt};
        c = field_age(W + 1);
        band = longint'(regs.step_band);
        sum2 = 0;
        for (int k = 0; k < 8; k++) begin
          d = (swap[k] ? c : field_age(ages[k])) - c;
          if (d > band) sum2 += 2 * d;
          else if (d > -band) sum2 += d;
        end
        vhe = clip32(c + scale_round(sum2, regs.mu_over_lambda, FRAC + 1));
        pull = scale_round(gc * (vhe - gc), regs.inv_lambda, 2 * FRAC);
        px.value = 32'(clip32(vhe - pull));
        px.last = (qr == last_row) && (qc == W - 1);
        pending.push_back(px);
      end
      if (row_pos >= rows + 1) begin
        row_pos = 0; col_pos = 0;
      end else if (++col_pos >= W) begin
        col_pos = 0; row_pos++;
      end
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic [31:0] value, logic last);
      pixel_t px;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel %h", value));
        return;
      end
      px = pending.pop_front();
      checked++;
      if (value !== px.value)
        report($sformatf("pixel %0d value %h, want %h", checked, value, px.value));
      if (last !== px.last)
        report($sformatf("pixel %0d last %b, want %b", checked, last, px.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;   // field_sample[31:0], guide_sample[63:32]
  logic                  in_tuser = 1'b0; // drain
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;       // new_value[31:0]
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mgvf_scoreboard sb = new();
  bit             calm;        // no idling on either side once set
  int             out_hold;
  int             items_sent, segments_run;
  int             frame_idx;   // position of the next item within the frame
  logic [31:0]    level;       // slowly drifting field level, keeps differences near the band

  always #10 clk = ~clk;

  mgvf_stencil_line_buffer_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Result side: check every transfer, stall in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
      if (calm) begin
        out_tready <= 1'b1;
      end else if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Hold the transfer until accepted; insert a random gap first now and then.
  task send_item(logic [31:0] f, logic [31:0] g, bit drn);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {g, f};
    in_tuser  <= drn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(f, g, drn);
    items_sent++;
  endtask

  function logic [31:0] pick_field();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
      2: begin
        level = $urandom;
        return level;
      end
      default: return level + 32'($urandom_range(0, 8000)) - 32'd4000;
    endcase
  endfunction

  function logic [31:0] pick_guide();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h07ff_ffff)) - 32'h0400_0000;
      default: return 32'($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000;
    endcase
  endfunction

  // One stretch of a frame under one register set; the frame position carries
  // over between stretches. A few items have their kind flipped.
  task run_segment(int rows, bit top, bit bot, logic [15:0] band, logic [30:0] mu,
                   logic [30:0] inv, bit directed, int count);
    int eff, total, i;
    bit drn;
    logic [31:0] corner [4] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
    write_reg(REG_ROWS_IN_USE, 31'(rows));
    write_reg(REG_TOP_IS_EDGE, 31'(top));
    write_reg(REG_BOTTOM_IS_EDGE, 31'(bot));
    write_reg(REG_STEP_BAND, 31'(band));
    write_reg(REG_MU_OVER_LAMBDA, mu);
    write_reg(REG_INV_LAMBDA, inv);
    eff = (rows < 3) ? 3 : (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
    total = eff * W + W + 1;
    for (int n = 0; n < count; n++) begin
      i = frame_idx;
      drn = i >= eff * W;
      // flip the kind now and then: drain inside the frame, sample in the tail
      if ($urandom_range(0, 49) == 0) drn = !drn;
      if (directed && i < 16)
        send_item(corner[i % 4], corner[i / 4], 1'b0);
      else if (directed && i >= 512 && i < 520)
        send_item(corner[i % 4], corner[(i + 1) % 4], i[0]);
      else
        send_item(pick_field(), pick_guide(), drn);
      frame_idx = (i + 1 >= total) ? 0 : i + 1;
    end
    in_tvalid <= 1'b0;
    // Let results drain out, then give in-flight work time before the next writes.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    segments_run++;
  endtask

  initial begin
    level = '0;
    frame_idx = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_segment(3, 1'b1, 1'b1, 16'd0, 31'h7fff_ffff, 31'd0, 1'b1, 560);
    run_segment(0, 1'b0, 1'b1, 16'hffff, 31'd0, 31'h7fff_ffff, 1'b0, 60);
    run_segment(5, 1'b1, 1'b0, 16'(BAND_RST), MU_RST, INV_RST, 1'b0, 110);
    run_segment(4, 1'b1, 1'b1, 16'($urandom), 31'($urandom_range(0, 32'h0400_0000)),
                31'($urandom_range(0, 32'h0200_0000)), 1'b0, 60);
    calm = 1'b1;
    run_segment(3, 1'b1, 1'b1, 16'($urandom_range(0, 4000)), 31'($urandom),
                31'($urandom), 1'b0, 60);
    $display("Ran %0d segments, %0d input transfers, %0d pixels checked,", segments_run,
             items_sent, sb.checked);
    $display("covering top edge and halo rows, left edge, extreme gains and misplaced drains.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
